/* design/mac_grid_rk2_particle_advect_assert.svh */
// Assertion macros shared by the advection block
`ifndef MAC_GRID_RK2_PARTICLE_ADVECT_ASSERT_SVH
`define MAC_GRID_RK2_PARTICLE_ADVECT_ASSERT_SVH
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`endif

/* design/mgra_pkg.sv */
// ----------------------------------------------------------------------------
// mgra_pkg
// Types and constants of the staggered grid particle advection block.
// ----------------------------------------------------------------------------
package mgra_pkg;
   localparam int FRAC_BITS = 20;
   typedef enum logic [1:0] {
      REQ_WRITE_U = 2'd0,
      REQ_WRITE_V = 2'd1,
      REQ_ADVECT  = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;
   typedef enum logic [2:0] {
      REG_CELL = 3'd0,
      REG_INV  = 3'd1,
      REG_STEP = 3'd2,
      REG_COLS = 3'd3,
      REG_ROWS = 3'd4
   } reg_index_type;
   typedef enum logic [3:0] {
      S_IDLE, S_GRID, S_IDX, S_RD, S_L0, S_L1, S_L2, S_STEP, S_MID, S_FIN, S_OUT
   } adv_state_type;
   typedef struct packed {
      logic        is_write;
      logic        is_u;
      logic [16:0] waddr;
      logic [31:0] wdata;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] a);
      if (a > 66'sd2147483647) return 32'sh7fffffff;
      if (a < -66'sd2147483648) return 32'sh80000000;
      return a[31:0];
   endfunction
endpackage

/* design/mgra_front.sv */
// ----------------------------------------------------------------------------
// mgra_front
// Accepts requests, classifies them and pushes commands into a short queue.
// ----------------------------------------------------------------------------
module mgra_front #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_type,
   input  logic [6:0] req_face_col,
   input  logic [6:0] req_face_row,
   input  logic signed [31:0] req_face_velocity,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   output logic q_valid,
   input  logic q_pop,
   output mgra_pkg::cmd_type q_cmd
);
   import mgra_pkg::*;
   cmd_type q_ff [2];
   cmd_type cmd_in;
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff, keep;
   logic push;
   assign req_ready = (cnt_ff != 2'd2);
   always_comb begin
      cmd_in = '0;
      keep = 1'b0;
      cmd_in.wdata = req_face_velocity;
      cmd_in.px = req_pos_x;
      cmd_in.py = req_pos_y;
      unique case (req_code_type'(req_type))
         REQ_WRITE_U: begin
            keep = ({25'd0, req_face_col} <= MAX_COLS) && ({25'd0, req_face_row} < MAX_ROWS);
            cmd_in.is_write = 1'b1;
            cmd_in.is_u = 1'b1;
            cmd_in.waddr = 17'(32'(req_face_row) * (MAX_COLS + 1) + 32'(req_face_col));
         end
         REQ_WRITE_V: begin
            keep = ({25'd0, req_face_col} < MAX_COLS) && ({25'd0, req_face_row} <= MAX_ROWS);
            cmd_in.is_write = 1'b1;
            cmd_in.waddr = 17'(32'(req_face_row) * MAX_COLS + 32'(req_face_col));
         end
         REQ_ADVECT: keep = 1'b1;
         default: keep = 1'b0;
      endcase
   end
   assign push = req_valid && req_ready && keep;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
         if (push) wr_ff <= ~wr_ff;
         if (q_pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[wr_ff] <= cmd_in;
   end
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = q_ff[rd_ff];
endmodule

/* design/mgra_back.sv */
// ----------------------------------------------------------------------------
// mgra_back
// Executes store writes and the two-stage midpoint advection sequence.
// ----------------------------------------------------------------------------
module mgra_back #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_pop,
   input  mgra_pkg::cmd_type q_cmd,
   input  logic [30:0] cell_size,
   input  logic [30:0] inv_size,
   input  logic [30:0] time_step,
   input  logic [6:0] grid_cols,
   input  logic [6:0] grid_rows,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y
);
   import mgra_pkg::*;
   localparam int UD = (MAX_COLS + 1) * MAX_ROWS;
   localparam int VD = MAX_COLS * (MAX_ROWS + 1);
   localparam int AW = $clog2(UD > VD ? UD : VD);
   logic signed [31:0] umem [UD];
   logic signed [31:0] vmem [VD];
   adv_state_type st_ff, st_in;
   logic pass_ff, pass_in;
   logic [1:0] k_ff, k_in;
   logic signed [31:0] px_ff, py_ff, gx_ff, gy_ff, mx_ff, my_ff;
   logic signed [31:0] ua_ff [4];
   logic signed [31:0] va_ff [4];
   logic signed [31:0] ud_ff, vd_ff;
   logic [AW-1:0] ua_ad, va_ad;
   logic [20:0] ufx_ff, ufy_ff, vfx_ff, vfy_ff;
   logic signed [31:0] ui_ff, uj_ff, vi_ff, vj_ff;
   logic signed [31:0] us_ff, vs_ff, ur0_ff, vr0_ff, ur1_ff, vr1_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic ov_ff;
   logic [1:0] rk_ff;
   logic [8:0] ec, er;
   logic wr_u, wr_v, rd_en;

   assign ec = (grid_cols < 7'd3) ? 9'd3 : ((32'(grid_cols) > MAX_COLS) ? 9'(MAX_COLS) : 9'(grid_cols));
   assign er = (grid_rows < 7'd3) ? 9'd3 : ((32'(grid_rows) > MAX_ROWS) ? 9'(MAX_ROWS) : 9'(grid_rows));

   function automatic logic signed [31:0] to_grid(input logic signed [31:0] p, input logic [30:0] s);
      logic signed [63:0] m;
      m = p * $signed({1'b0, s});
      return sat32(66'(m >>> FRAC_BITS));
   endfunction
   function automatic logic signed [31:0] clampi(input logic signed [31:0] a, input logic [8:0] hi);
      if (a < 0) return 0;
      if (a > $signed({23'd0, hi})) return $signed({23'd0, hi});
      return a;
   endfunction
   function automatic logic signed [31:0] lerp(input logic signed [31:0] a, input logic signed [31:0] b,
                                               input logic [20:0] f);
      logic signed [65:0] t;
      t = a * $signed({1'b0, 21'h100000 - f}) + b * $signed({1'b0, f});
      return t[51:20];
   endfunction

   // corner k: bit0 = +1 x, bit1 = +1 y
   always_comb begin
      logic signed [31:0] c, r;
      c = clampi(ui_ff + 32'(k_ff[0]), ec);
      r = clampi(uj_ff + 32'(k_ff[1]), er - 9'd1);
      ua_ad = AW'(r * (MAX_COLS + 1) + c);
      c = clampi(vi_ff + 32'(k_ff[0]), ec - 9'd1);
      r = clampi(vj_ff + 32'(k_ff[1]), er);
      va_ad = AW'(r * MAX_COLS + c);
   end

   assign wr_u = (st_ff == S_IDLE) && q_valid && q_cmd.is_write && q_cmd.is_u;
   assign wr_v = (st_ff == S_IDLE) && q_valid && q_cmd.is_write && !q_cmd.is_u;
   assign rd_en = (st_ff == S_RD);
   always_ff @(posedge clock) begin
      if (wr_u) umem[q_cmd.waddr[AW-1:0]] <= q_cmd.wdata;
      if (wr_v) vmem[q_cmd.waddr[AW-1:0]] <= q_cmd.wdata;
      if (rd_en) begin
         ud_ff <= umem[ua_ad];
         vd_ff <= vmem[va_ad];
      end
   end

   always_comb begin
      st_in = st_ff; pass_in = pass_ff; k_in = k_ff; q_pop = 1'b0;
      unique case (st_ff)
         S_IDLE: if (q_valid) begin
            q_pop = 1'b1;
            if (!q_cmd.is_write) begin st_in = S_GRID; pass_in = 1'b0; end
         end
         S_GRID: st_in = S_IDX;
         S_IDX: begin st_in = S_RD; k_in = 2'd0; end
         S_RD: begin k_in = k_ff + 2'd1; if (k_ff == 2'd3) st_in = S_L0; end
         S_L0: st_in = S_L1;
         S_L1: st_in = S_L2;
         S_L2: st_in = S_STEP;
         S_STEP: st_in = pass_ff ? S_FIN : S_MID;
         S_MID: begin st_in = S_GRID; pass_in = 1'b1; end
         S_FIN: st_in = S_OUT;
         S_OUT: if (!ov_ff || rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      logic signed [31:0] qx, qy;
      logic signed [63:0] tx, ty;
      logic signed [31:0] hx, hy, lo;
      logic signed [32:0] sx, sy;
      if (reset) begin
         st_ff <= S_IDLE; pass_ff <= 1'b0; k_ff <= '0; ov_ff <= 1'b0; rk_ff <= '0;
      end else begin
         st_ff <= st_in; pass_ff <= pass_in; k_ff <= k_in;
         rk_ff <= k_ff;
         if (ov_ff && rsp_ready) ov_ff <= 1'b0;
         if (st_ff == S_OUT && (!ov_ff || rsp_ready)) ov_ff <= 1'b1;
      end
      if (st_ff == S_IDLE) begin px_ff <= q_cmd.px; py_ff <= q_cmd.py; end
      if (st_ff == S_GRID) begin
         gx_ff <= to_grid(pass_ff ? mx_ff : px_ff, inv_size);
         gy_ff <= to_grid(pass_ff ? my_ff : py_ff, inv_size);
      end
      if (st_ff == S_IDX) begin
         sx = $signed({gx_ff[31], gx_ff}) - 33'sh80000;
         sy = $signed({gy_ff[31], gy_ff}) - 33'sh80000;
         ui_ff <= gx_ff >>> FRAC_BITS; ufx_ff <= {1'b0, gx_ff[19:0]};
         uj_ff <= 32'(sy >>> FRAC_BITS);
         ufy_ff <= {1'b0, sy[19:0]};
         vi_ff <= 32'(sx >>> FRAC_BITS);
         vfx_ff <= {1'b0, sx[19:0]};
         vj_ff <= gy_ff >>> FRAC_BITS; vfy_ff <= {1'b0, gy_ff[19:0]};
      end
      if (st_ff == S_L0 || (st_ff == S_RD && k_ff != 2'd0)) begin
         ua_ff[rk_ff] <= ud_ff; va_ff[rk_ff] <= vd_ff;
      end
      if (st_ff == S_L1) begin
         ur0_ff <= lerp(ua_ff[0], ua_ff[1], ufx_ff);
         ur1_ff <= lerp(ua_ff[2], ua_ff[3], ufx_ff);
         vr0_ff <= lerp(va_ff[0], va_ff[1], vfx_ff);
         vr1_ff <= lerp(va_ff[2], va_ff[3], vfx_ff);
      end
      if (st_ff == S_L2) begin
         us_ff <= lerp(ur0_ff, ur1_ff, ufy_ff);
         vs_ff <= lerp(vr0_ff, vr1_ff, vfy_ff);
      end
      tx = $signed({1'b0, time_step}) * us_ff;
      ty = $signed({1'b0, time_step}) * vs_ff;
      if (st_ff == S_STEP) begin
         if (!pass_ff) begin
            mx_ff <= sat32(66'(px_ff) + 66'(tx >>> (FRAC_BITS + 1)));
            my_ff <= sat32(66'(py_ff) + 66'(ty >>> (FRAC_BITS + 1)));
         end else begin
            ox_ff <= sat32(66'(px_ff) + 66'(tx >>> FRAC_BITS));
            oy_ff <= sat32(66'(py_ff) + 66'(ty >>> FRAC_BITS));
         end
      end
      if (st_ff == S_FIN) begin
         lo = {2'b0, cell_size[30:1]};
         hx = sat32(66'(($signed({1'b0, 2 * ec - 10'd1}) * $signed({1'b0, cell_size})) >>> 1));
         hy = sat32(66'(($signed({1'b0, 2 * er - 10'd1}) * $signed({1'b0, cell_size})) >>> 1));
         qx = ox_ff > hx ? hx : ox_ff; qx = qx < lo ? lo : qx;
         qy = oy_ff > hy ? hy : oy_ff; qy = qy < lo ? lo : qy;
         ox_ff <= qx; oy_ff <= qy;
      end
      if (st_ff == S_OUT && (!ov_ff || rsp_ready)) begin
         rsp_new_x <= ox_ff; rsp_new_y <= oy_ff;
      end
   end
   assign rsp_valid = ov_ff;

`include "mac_grid_rk2_particle_advect_assert.svh"
   `ASSERT_IMPL(a_pop_idle, clock, reset, q_pop |-> (st_ff == S_IDLE && q_valid))
   `ASSERT_IMPL(a_hold, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_new_x))
   `ASSERT_NEVER(a_wr_rd, clock, reset, (wr_u || wr_v) && rd_en)
endmodule

/* design/mac_grid_rk2_particle_advect.sv */
// ----------------------------------------------------------------------------
// mac_grid_rk2_particle_advect
// Staggered grid velocity stores with midpoint particle advection.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// req     | in  | req_valid/ready  | type, face col/row/velocity, pos x/y
// rsp     | out | rsp_valid/ready  | new_x, new_y
// csr     | in  | APB psel/penable | five registers at 4*i
// A write is done in the idle state of the back end; an advect runs two
// passes of four reads each from the single-port u and v memories plus
// the interpolation and step pipeline. A two-entry queue decouples intake.
// Reset is synchronous; memory contents are undefined until written.
// A stalled result holds in the output register while the next item runs.
module mac_grid_rk2_particle_advect #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_type,
   input  logic [6:0] req_face_col,
   input  logic [6:0] req_face_row,
   input  logic signed [31:0] req_face_velocity,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import mgra_pkg::*;
   logic [30:0] cs_ff, inv_ff, dt_ff;
   logic [6:0] gc_ff, gr_ff;
   logic q_valid, q_pop;
   cmd_type q_cmd;
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= 31'd1048576; inv_ff <= 31'd1048576; dt_ff <= 31'd10486;
         gc_ff <= 7'd64; gr_ff <= 7'd64;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            REG_CELL: cs_ff <= pwdata[30:0];
            REG_INV:  inv_ff <= pwdata[30:0];
            REG_STEP: dt_ff <= pwdata[30:0];
            REG_COLS: gc_ff <= pwdata[6:0];
            REG_ROWS: gr_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (paddr[4:2])
         REG_CELL: prdata = {1'b0, cs_ff};
         REG_INV:  prdata = {1'b0, inv_ff};
         REG_STEP: prdata = {1'b0, dt_ff};
         REG_COLS: prdata = {25'd0, gc_ff};
         REG_ROWS: prdata = {25'd0, gr_ff};
         default:  prdata = '0;
      endcase
   end
   mgra_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_face_col,
      .req_face_row, .req_face_velocity, .req_pos_x, .req_pos_y,
      .q_valid, .q_pop, .q_cmd);
   mgra_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_cmd, .cell_size(cs_ff),
      .inv_size(inv_ff), .time_step(dt_ff), .grid_cols(gc_ff), .grid_rows(gr_ff),
      .rsp_valid, .rsp_ready, .rsp_new_x, .rsp_new_y);
endmodule
